// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define CHK_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define CHK_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: rtl/stramp_pkg.sv
// Types and constants of the stepper trapezoid ramp generator.
package stramp_pkg;

    localparam int COUNT_W   = 32;                 // step counters and ramp index
    localparam int TIMER_W   = 16;                 // interval integer part, tick counter
    localparam int FRAC_W    = 8;                  // interval fraction bits
    localparam int IVAL_W    = TIMER_W + FRAC_W;   // fixed-point interval
    localparam int POS_W     = 32;
    localparam int CFG_W     = 16;                 // interval registers
    localparam int DIVD_W    = IVAL_W + 1;         // dividend 2*d
    localparam int DIVS_W    = COUNT_W + 2;        // divisor 4n+1 or 4n-1
    localparam int DIV_CNT_W = $clog2(DIVD_W);
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;

    localparam logic [1:0] REG_INIT_IVAL = 2'd0;
    localparam logic [1:0] REG_MIN_IVAL  = 2'd1;
    localparam logic [1:0] REG_DIR_INV   = 2'd2;

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_REL_MOVE = 2'd1,
        OP_ABS_MOVE = 2'd2,
        OP_ZERO_POS = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RAMP,
        S_DIV,
        S_FIX,
        S_OUT
    } t_state;

    typedef enum logic {
        DIV_ACCEL,
        DIV_DECEL
    } t_div_mode;

    typedef struct packed {
        t_opcode            opcode;
        logic signed [31:0] steps;
        logic               stop_at_endstop;
        logic               endstop_hit;
    } t_cmd;

    typedef struct packed {
        logic               step_pulse;
        logic               dir_level;
        logic signed [31:0] position;
        logic               busy_res;
        logic               move_done;
        logic [15:0]        current_interval;
    } t_res;

endpackage

// File: rtl/stepper_trapezoid_ramp.sv
// Single-axis stepper pulse generator with a trapezoidal speed ramp.
// Each input transaction (timer tick, relative move, absolute move, zero position)
// yields exactly one result transaction carrying the pulse flag, direction level,
// position, busy/done flags and the integer part of the step interval. Ticks that
// cause no step event, end-stop aborts and all other commands pass only through the
// command and output states. A step event that ramps the interval also passes through
// the ramp-decision state and one shared restoring divider that computes the ramp update
// d -/+ floor(2d / (4n +/- 1)), one quotient bit per cycle over the 25-bit dividend 2d,
// followed by a fix-up state before the output state. A step event in cruise, or in
// deceleration once the ramp index is back at zero, skips the divider and the fix-up
// state. The input side stalls from
// acceptance until the result is loaded into the output register; a stalled result
// holds the block in its output state while the stall lasts, and the
// output register lets a finished result wait while the next transaction is taken.
// Configuration goes through an APB-style port: initial interval at 0x0, minimum
// interval at 0x4, direction invert at 0x8.
module stepper_trapezoid_ramp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  stramp_pkg::t_cmd              i_cmd,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output stramp_pkg::t_res              o_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [stramp_pkg::ADDR_W-1:0] paddr,
    input  logic [stramp_pkg::DATA_W-1:0] pwdata,
    output logic [stramp_pkg::DATA_W-1:0] prdata,
    output logic                          pready
);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [stramp_pkg::CFG_W-1:0] r_init_ival;
    logic [stramp_pkg::CFG_W-1:0] r_min_ival;
    logic                         r_dir_inv;
    logic                         cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_ival <= stramp_pkg::CFG_W'(5000);
            r_min_ival  <= stramp_pkg::CFG_W'(100);
            r_dir_inv   <= 1'b1;
        end else if (cfg_we) begin
            unique case (paddr[3:2])
                stramp_pkg::REG_INIT_IVAL: r_init_ival <= pwdata[stramp_pkg::CFG_W-1:0];
                stramp_pkg::REG_MIN_IVAL:  r_min_ival  <= pwdata[stramp_pkg::CFG_W-1:0];
                stramp_pkg::REG_DIR_INV:   r_dir_inv   <= pwdata[0];
                default: ;  // unmapped address: drop the write
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            stramp_pkg::REG_INIT_IVAL:
                prdata = stramp_pkg::DATA_W'(r_init_ival);
            stramp_pkg::REG_MIN_IVAL:
                prdata = stramp_pkg::DATA_W'(r_min_ival);
            stramp_pkg::REG_DIR_INV:
                prdata = stramp_pkg::DATA_W'(r_dir_inv);
            default:
                prdata = '0;
        endcase
    end

    // Tick count to fixed point, saturating at the interval width.
    function automatic logic [stramp_pkg::IVAL_W-1:0] to_fixed(
        input logic [stramp_pkg::CFG_W-1:0] v
    );
        logic [stramp_pkg::CFG_W+stramp_pkg::FRAC_W-1:0] ext;
        ext = {v, {stramp_pkg::FRAC_W{1'b0}}};
        if ((ext >> stramp_pkg::IVAL_W) != '0) begin
            to_fixed = '1;
        end else begin
            to_fixed = stramp_pkg::IVAL_W'(ext);
        end
    endfunction

    // Step magnitude clamped to the counter width.
    function automatic logic [stramp_pkg::COUNT_W-1:0] sat_count(input logic [31:0] m);
        if ((33'(m) >> stramp_pkg::COUNT_W) != '0) begin
            sat_count = '1;
        end else begin
            sat_count = stramp_pkg::COUNT_W'(m);
        end
    endfunction

    // ---------------------------------------------------------------
    // Sequencer, motion state, divider and output register
    // ---------------------------------------------------------------
    stramp_pkg::t_state    r_state, n_state;
    stramp_pkg::t_cmd      r_cmd;
    logic                  r_pulse, n_pulse;

    logic [stramp_pkg::IVAL_W-1:0]  r_ival, n_ival;
    logic [stramp_pkg::COUNT_W-1:0] r_ramp_idx, n_ramp_idx;
    logic [stramp_pkg::COUNT_W-1:0] r_step_cnt, n_step_cnt;
    logic [stramp_pkg::COUNT_W-1:0] r_move_len, n_move_len;
    logic [stramp_pkg::COUNT_W-1:0] r_ramp_up, n_ramp_up;
    logic [stramp_pkg::POS_W-1:0]   r_pos, n_pos;
    logic [stramp_pkg::TIMER_W-1:0] r_tick, n_tick;
    logic r_active, n_active;
    logic r_es_mode, n_es_mode;
    logic r_dir_neg, n_dir_neg;
    logic r_dir_pin, n_dir_pin;
    logic r_done, n_done;

    stramp_pkg::t_div_mode            r_div_mode, n_div_mode;
    logic [stramp_pkg::DIVS_W-1:0]    r_rem, n_rem;
    logic [stramp_pkg::DIVD_W-1:0]    r_dvd, n_dvd;   // dividend in, quotient out
    logic [stramp_pkg::DIVS_W-1:0]    r_dvs, n_dvs;
    logic [stramp_pkg::DIV_CNT_W-1:0] r_div_cnt, n_div_cnt;

    logic             r_out_valid, n_out_valid;
    stramp_pkg::t_res r_out, n_out;

    logic accept_in;
    logic out_free;

    assign o_in_stall  = (r_state != stramp_pkg::S_IDLE);
    assign accept_in   = i_in_valid & ~o_in_stall;
    assign out_free    = ~r_out_valid | ~i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_res       = r_out;

    // Combinational helpers shared by the next-state and datapath blocks.
    logic [stramp_pkg::TIMER_W-1:0] tick_inc;
    logic                           step_event;
    logic [stramp_pkg::COUNT_W-1:0] ramp_idx_inc;
    logic                           decel_zone;
    logic [stramp_pkg::DIVS_W:0]    rem_sh;
    logic [stramp_pkg::DIVS_W:0]    rem_diff;
    logic [stramp_pkg::DIVD_W-1:0]  d_acc;
    logic [stramp_pkg::DIVD_W:0]    d_dec;
    logic [stramp_pkg::IVAL_W-1:0]  ival_lim;
    logic [31:0]                    move_dist;
    logic [31:0]                    dist_mag;
    logic                           dist_neg;
    logic                           dir_flip;

    assign tick_inc     = r_tick + 1'b1;
    assign step_event   = (tick_inc >= r_ival[stramp_pkg::IVAL_W-1:stramp_pkg::FRAC_W]);
    assign ramp_idx_inc = r_ramp_idx + 1'b1;
    assign decel_zone   = (r_step_cnt >= (r_move_len - r_ramp_up));
    assign rem_sh       = {r_rem, r_dvd[stramp_pkg::DIVD_W-1]};
    assign rem_diff     = rem_sh - {1'b0, r_dvs};
    assign d_acc        = {1'b0, r_ival} - r_dvd;
    assign d_dec        = {2'b00, r_ival} + {1'b0, r_dvd};
    assign ival_lim     = to_fixed(r_min_ival);
    assign move_dist    = (r_cmd.opcode == stramp_pkg::OP_REL_MOVE) ?
                          r_cmd.steps : (r_cmd.steps - r_pos);
    assign dist_neg     = move_dist[31];
    assign dist_mag     = dist_neg ? (32'd0 - move_dist) : move_dist;
    assign dir_flip     = (r_cmd.opcode == stramp_pkg::OP_REL_MOVE) & r_dir_inv;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            stramp_pkg::S_IDLE: begin
                if (accept_in) begin
                    n_state = stramp_pkg::S_EXEC;
                end
            end
            stramp_pkg::S_EXEC: begin
                n_state = stramp_pkg::S_OUT;
                // Only a step that does not hit the end stop updates the ramp.
                if (r_cmd.opcode == stramp_pkg::OP_TICK && r_active && step_event &&
                    !(r_es_mode && r_cmd.endstop_hit)) begin
                    n_state = stramp_pkg::S_RAMP;
                end
            end
            stramp_pkg::S_RAMP: begin
                if (r_ramp_up == '0) begin
                    n_state = stramp_pkg::S_DIV;
                end else if (decel_zone && r_ramp_idx != '0) begin
                    n_state = stramp_pkg::S_DIV;
                end else begin
                    n_state = stramp_pkg::S_OUT;
                end
            end
            stramp_pkg::S_DIV: begin
                if (r_div_cnt == '0) begin
                    n_state = stramp_pkg::S_FIX;
                end
            end
            stramp_pkg::S_FIX: begin
                n_state = stramp_pkg::S_OUT;
            end
            stramp_pkg::S_OUT: begin
                if (out_free) begin
                    n_state = stramp_pkg::S_IDLE;
                end
            end
            default: n_state = stramp_pkg::S_IDLE;
        endcase
    end

    // Datapath next values
    always_comb begin
        n_pulse     = r_pulse;
        n_ival      = r_ival;
        n_ramp_idx  = r_ramp_idx;
        n_step_cnt  = r_step_cnt;
        n_move_len  = r_move_len;
        n_ramp_up   = r_ramp_up;
        n_pos       = r_pos;
        n_tick      = r_tick;
        n_active    = r_active;
        n_es_mode   = r_es_mode;
        n_dir_neg   = r_dir_neg;
        n_dir_pin   = r_dir_pin;
        n_done      = r_done;
        n_div_mode  = r_div_mode;
        n_rem       = r_rem;
        n_dvd       = r_dvd;
        n_dvs       = r_dvs;
        n_div_cnt   = r_div_cnt;
        n_out       = r_out;
        n_out_valid = r_out_valid & i_out_stall;

        unique case (r_state)
            stramp_pkg::S_EXEC: begin
                n_pulse = 1'b0;
                case (r_cmd.opcode)
                    stramp_pkg::OP_TICK: begin
                        if (r_active) begin
                            if (step_event) begin
                                n_tick = '0;
                                if (r_es_mode && r_cmd.endstop_hit) begin
                                    // abort without a step; keep the done flag
                                    n_active = 1'b0;
                                end else if (r_step_cnt < r_move_len) begin
                                    n_pulse    = 1'b1;
                                    n_step_cnt = r_step_cnt + 1'b1;
                                    n_pos      = r_dir_neg ? (r_pos - 1'b1) : (r_pos + 1'b1);
                                    if ((r_step_cnt + 1'b1) >= r_move_len) begin
                                        n_done   = 1'b1;
                                        n_active = 1'b0;
                                    end
                                end
                            end else begin
                                n_tick = tick_inc;
                            end
                        end
                    end
                    stramp_pkg::OP_REL_MOVE, stramp_pkg::OP_ABS_MOVE: begin
                        // Zero distance: ignore the command entirely.
                        if (move_dist != '0) begin
                            n_dir_pin  = dir_flip ? ~dist_neg : dist_neg;
                            n_dir_neg  = dir_flip ? ~dist_neg : dist_neg;
                            n_move_len = sat_count(dist_mag);
                            n_ival     = to_fixed(r_init_ival);
                            n_step_cnt = '0;
                            n_ramp_idx = '0;
                            n_ramp_up  = '0;
                            n_done     = 1'b0;
                            n_tick     = '0;
                            n_es_mode  = r_cmd.stop_at_endstop;
                            n_active   = 1'b1;
                        end
                    end
                    default: begin
                        n_pos = '0;
                    end
                endcase
            end
            stramp_pkg::S_RAMP: begin
                // Load the divider with 2d and 4n+1 (accelerate) or 4n-1 (decelerate).
                n_rem     = '0;
                n_dvd     = {r_ival, 1'b0};
                n_div_cnt = stramp_pkg::DIV_CNT_W'(stramp_pkg::DIVD_W - 1);
                if (r_ramp_up == '0) begin
                    n_ramp_idx = ramp_idx_inc;
                    n_div_mode = stramp_pkg::DIV_ACCEL;
                    n_dvs      = {ramp_idx_inc, 2'b01};
                end else begin
                    n_div_mode = stramp_pkg::DIV_DECEL;
                    n_dvs      = {r_ramp_idx - 1'b1, 2'b11};
                end
            end
            stramp_pkg::S_DIV: begin
                // One restoring step: shift in a dividend bit, subtract if it fits.
                if (!rem_diff[stramp_pkg::DIVS_W]) begin
                    n_rem = rem_diff[stramp_pkg::DIVS_W-1:0];
                    n_dvd = {r_dvd[stramp_pkg::DIVD_W-2:0], 1'b1};
                end else begin
                    n_rem = rem_sh[stramp_pkg::DIVS_W-1:0];
                    n_dvd = {r_dvd[stramp_pkg::DIVD_W-2:0], 1'b0};
                end
                n_div_cnt = r_div_cnt - 1'b1;
            end
            stramp_pkg::S_FIX: begin
                if (r_div_mode == stramp_pkg::DIV_ACCEL) begin
                    if (d_acc <= {1'b0, ival_lim}) begin
                        n_ival = ival_lim;
                    end else begin
                        n_ival = d_acc[stramp_pkg::IVAL_W-1:0];
                    end
                    // Cruise starts at the speed limit or at half the move.
                    if (d_acc <= {1'b0, ival_lim} || r_step_cnt >= (r_move_len >> 1)) begin
                        n_ramp_up = r_step_cnt;
                    end
                end else begin
                    if ((d_dec >> stramp_pkg::IVAL_W) != '0) begin
                        n_ival = '1;
                    end else begin
                        n_ival = d_dec[stramp_pkg::IVAL_W-1:0];
                    end
                    n_ramp_idx = r_ramp_idx - 1'b1;
                end
            end
            stramp_pkg::S_OUT: begin
                if (out_free) begin
                    n_out_valid            = 1'b1;
                    n_out.step_pulse       = r_pulse;
                    n_out.dir_level        = r_dir_pin;
                    n_out.position         = r_pos;
                    n_out.busy_res         = r_active;
                    n_out.move_done        = r_done;
                    n_out.current_interval = 16'(r_ival >> stramp_pkg::FRAC_W);
                end
            end
            default: ;
        endcase
    end

    // Control and motion state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= stramp_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_ival      <= '0;
            r_ramp_idx  <= '0;
            r_step_cnt  <= '0;
            r_move_len  <= '0;
            r_ramp_up   <= '0;
            r_pos       <= '0;
            r_tick      <= '0;
            r_active    <= 1'b0;
            r_es_mode   <= 1'b0;
            r_dir_neg   <= 1'b0;
            r_dir_pin   <= 1'b0;
            r_done      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_ival      <= n_ival;
            r_ramp_idx  <= n_ramp_idx;
            r_step_cnt  <= n_step_cnt;
            r_move_len  <= n_move_len;
            r_ramp_up   <= n_ramp_up;
            r_pos       <= n_pos;
            r_tick      <= n_tick;
            r_active    <= n_active;
            r_es_mode   <= n_es_mode;
            r_dir_neg   <= n_dir_neg;
            r_dir_pin   <= n_dir_pin;
            r_done      <= n_done;
        end
    end

    // Payload: command capture, divider and result register
    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_cmd <= i_cmd;
        end
        r_pulse    <= n_pulse;
        r_div_mode <= n_div_mode;
        r_rem      <= n_rem;
        r_dvd      <= n_dvd;
        r_dvs      <= n_dvs;
        r_div_cnt  <= n_div_cnt;
        r_out      <= n_out;
    end

endmodule

// File: rtl/stramp_checker.sv
// Port-level checker for the stepper trapezoid ramp generator, with its bind.
`include "assert_macros.svh"

module stramp_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             o_in_stall,
    input stramp_pkg::t_cmd i_cmd,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input stramp_pkg::t_res o_res
);

    logic in_acc;
    logic out_acc;

    assign in_acc  = i_in_valid & ~o_in_stall;
    assign out_acc = o_out_valid & ~i_out_stall;

    // One transaction at a time: the block is busy right after taking one.
    `CHK_NEXT(a_busy_after_accept, in_acc, o_in_stall)

    // A stalled result stays and holds its value.
    `CHK_NEXT(a_result_holds, o_out_valid && i_out_stall, o_out_valid && $stable(o_res))

    // A pulse that ends the move must report the move as done.
    `CHK_IMPLY(a_last_pulse_done, out_acc && o_res.step_pulse && !o_res.busy_res,
               o_res.move_done)

endmodule

bind stepper_trapezoid_ramp stramp_checker u_stramp_checker (.*);
